[rtl/motor_feedback_frame_unwrap_macros.svh]
// Assertion macros shared by the motor feedback unwrap RTL.
`ifndef MOTOR_FEEDBACK_FRAME_UNWRAP_MACROS_SVH
`define MOTOR_FEEDBACK_FRAME_UNWRAP_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define MFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define MFU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define MFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFU_ASSERT(lbl, prop, msg)
`define MFU_ASSERT_SAME(lbl, ante, cons, msg)
`define MFU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/mfu_pkg.sv]
// Types and constants shared by the motor feedback unwrap modules.
`default_nettype none
package mfu_pkg;

  localparam int ID_W      = 11;
  localparam int THR_W     = 15;
  localparam int POS_W     = 16;
  localparam int REL_W     = 30;
  localparam int TEMP_W    = 8;
  localparam int PAYLOAD_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;

  // Stream widths: field bits packed from bit 0, tdata padded to whole bytes
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 1;

  localparam logic [ID_W-1:0]  FIRST_ID_RST  = 11'h205;
  localparam logic [ID_W-1:0]  SECOND_ID_RST = 11'h206;
  localparam logic [THR_W-1:0] THR_RST       = 15'd5000;

  localparam logic signed [POS_W-1:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] TURN_MIN = -16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ID  = 2'd0,
    CFG_SECOND_ID = 2'd1,
    CFG_WRAP_THR  = 2'd2
  } cfg_idx_e;

  // Turn tracker update request
  typedef struct packed {
    logic                    en;
    logic                    motor;
    logic signed [POS_W-1:0] pos;
  } upd_t;

  // Result payload, most significant field first
  typedef struct packed {
    logic        [TEMP_W-1:0] temperature;
    logic signed [POS_W-1:0]  torque;
    logic signed [POS_W-1:0]  velocity;
    logic signed [REL_W-1:0]  relative_position;
    logic signed [POS_W-1:0]  turn_count;
    logic signed [POS_W-1:0]  raw_position;
  } res_t;

endpackage
`default_nettype wire

[rtl/mfu_turn_track.sv]
// Per-motor last position, turn count and seen flag with wrap detection.
`default_nettype none
`include "motor_feedback_frame_unwrap_macros.svh"
module mfu_turn_track import mfu_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire upd_t                    upd_i,
  input  wire logic        [THR_W-1:0] thr_i,
  output      logic signed [POS_W-1:0] turns_o
);

  logic signed [POS_W-1:0] last_q  [2];
  logic signed [POS_W-1:0] turns_q [2];
  logic                    seen_q  [2];

  logic signed [POS_W-1:0] last_sel;
  logic signed [POS_W-1:0] turns_sel;
  logic                    seen_sel;
  logic signed [POS_W:0]   diff;
  logic signed [POS_W:0]   thr_pos;
  logic signed [POS_W:0]   thr_neg;
  logic signed [POS_W-1:0] turns_d;

  // Pick the addressed motor's state
  assign last_sel  = last_q[upd_i.motor];
  assign turns_sel = turns_q[upd_i.motor];
  assign seen_sel  = seen_q[upd_i.motor];

  // Exact 17-bit jump and threshold bounds
  assign diff    = {upd_i.pos[POS_W-1], upd_i.pos} - {last_sel[POS_W-1], last_sel};
  assign thr_pos = $signed({2'b00, thr_i});
  assign thr_neg = -thr_pos;

  // Step the turn count on a wrap, holding at the limits
  always_comb begin
    turns_d = turns_sel;
    if (seen_sel) begin
      if (diff > thr_pos) begin
        if (turns_sel != TURN_MIN) turns_d = turns_sel - 16'sd1;
      end else if (diff < thr_neg) begin
        if (turns_sel != TURN_MAX) turns_d = turns_sel + 16'sd1;
      end
    end
  end

  assign turns_o = turns_d;

  // Commit the state of the addressed motor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q[0]  <= '0;
      last_q[1]  <= '0;
      turns_q[0] <= '0;
      turns_q[1] <= '0;
      seen_q[0]  <= 1'b0;
      seen_q[1]  <= 1'b0;
    end else if (upd_i.en) begin
      last_q[upd_i.motor]  <= upd_i.pos;
      turns_q[upd_i.motor] <= turns_d;
      seen_q[upd_i.motor]  <= 1'b1;
    end
  end

  `MFU_ASSERT_SAME(a_unseen_zero_turns, !seen_q[0], turns_q[0] == 16'sd0, "turns before first frame")
  `MFU_ASSERT_NEXT(a_motor0_hold, !(upd_i.en && !upd_i.motor), $stable(turns_q[0]), "motor 0 turns moved")
  `MFU_ASSERT_NEXT(a_motor1_hold, !(upd_i.en && upd_i.motor), $stable(turns_q[1]), "motor 1 turns moved")

endmodule
`default_nettype wire

[rtl/mfu_rel_scale.sv]
// Relative position: turns times counts per turn plus raw position, saturated.
`default_nettype none
module mfu_rel_scale import mfu_pkg::*; #(
  parameter int COUNTS_PER_TURN = 8192
) (
  input  wire logic signed [POS_W-1:0] turns_i,
  input  wire logic signed [POS_W-1:0] pos_i,
  output      logic signed [REL_W-1:0] rel_o
);

  localparam int CPT_W   = $clog2(COUNTS_PER_TURN + 1);
  localparam int PROD_W  = POS_W + CPT_W + 1;
  localparam int SUM_RAW = PROD_W + 1;
  localparam int SUM_W   = (SUM_RAW > REL_W + 1) ? SUM_RAW : REL_W + 1;
  localparam logic signed [CPT_W:0] CPT = (CPT_W + 1)'(COUNTS_PER_TURN);

  logic signed [PROD_W-1:0]     prod;
  logic signed [SUM_W-1:0]      sum;
  logic        [SUM_W-REL_W:0]  upper;

  // Scale and offset
  assign prod  = PROD_W'(turns_i) * PROD_W'(CPT);
  assign sum   = SUM_W'(prod) + SUM_W'(pos_i);
  assign upper = sum[SUM_W-1:REL_W-1];

  // Clamp to the signed result range
  always_comb begin
    if ((&upper) || !(|upper)) begin
      rel_o = sum[REL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      rel_o = {1'b1, {(REL_W-1){1'b0}}};
    end else begin
      rel_o = {1'b0, {(REL_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

[rtl/motor_feedback_frame_unwrap.sv]
// Top level: CAN feedback frame filter, decoder and multi-turn position unwrap.
`default_nettype none
`include "motor_feedback_frame_unwrap_macros.svh"
// Takes one received CAN frame per cycle on the slave stream and gives one
// result transfer for each standard data frame whose ID matches the first or
// the second motor register (the first wins when both are equal); every other
// frame is dropped without a result. A frame lands in an input register, is
// filtered, decoded and unwrapped in a single pass (17-bit jump compare, turn
// step, one multiply-add with saturation) and is written to the result
// register, and a new frame is taken every cycle as long as the result
// register is free or being drained. Consecutive frames
// for the same motor see each other's turn state without stalling, since the
// per-motor state is updated in the same cycle the frame leaves the input
// register. Configuration writes are always accepted and should
// be made while no frame is in flight.
module motor_feedback_frame_unwrap import mfu_pkg::*; #(
  parameter int COUNTS_PER_TURN = 8192
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write channel
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]   cfg_data_i,
  // Frame input
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  // [10:0] frame_id, [74:11] payload, [79:75] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] is_extended, [1] is_remote
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  // Result output
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [15:0] raw_position, [31:16] turn_count, [61:32] relative_position,
  // [77:62] velocity, [93:78] torque, [101:94] temperature, [103:102] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] motor_index
  output      logic [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  logic [ID_W-1:0]      first_id_q;
  logic [ID_W-1:0]      second_id_q;
  logic [THR_W-1:0]     thr_q;

  logic                 in_valid_q, in_valid_d;
  logic [ID_W-1:0]      id_q;
  logic                 ext_q;
  logic                 rtr_q;
  logic [PAYLOAD_W-1:0] payload_q;

  logic                 out_valid_q, out_valid_d;
  logic                 out_motor_q;
  res_t                 res_q;
  res_t                 res_d;

  logic                 in_take;
  logic                 hit_first;
  logic                 hit_second;
  logic                 match;
  logic                 out_free;
  logic                 in_fire;
  upd_t                 upd;
  logic signed [POS_W-1:0] turns_new;
  logic signed [REL_W-1:0] rel;
  cfg_idx_e             cfg_idx;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_id_q  <= FIRST_ID_RST;
      second_id_q <= SECOND_ID_RST;
      thr_q       <= THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx)
        CFG_FIRST_ID:  first_id_q  <= cfg_data_i[ID_W-1:0];
        CFG_SECOND_ID: second_id_q <= cfg_data_i[ID_W-1:0];
        CFG_WRAP_THR:  thr_q       <= cfg_data_i[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  // Filter the held frame
  assign hit_first  = (id_q == first_id_q);
  assign hit_second = (id_q == second_id_q);
  assign match      = !ext_q && !rtr_q && (hit_first || hit_second);

  // Advance: rejected frames drop at once, matches need a free result slot
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_fire         = in_valid_q && (!match || out_free);
  assign s_axis_tready_o = !in_valid_q || in_fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (in_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the incoming frame
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      id_q      <= s_axis_tdata_i[ID_W-1:0];
      payload_q <= s_axis_tdata_i[ID_W+PAYLOAD_W-1:ID_W];
      ext_q     <= s_axis_tuser_i[0];
      rtr_q     <= s_axis_tuser_i[1];
    end
  end

  // Turn tracking and scaling
  assign upd.en    = in_fire && match;
  assign upd.motor = !hit_first;
  assign upd.pos   = payload_q[63:48];

  mfu_turn_track u_turn_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .thr_i   (thr_q),
    .turns_o (turns_new)
  );

  mfu_rel_scale #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
  ) u_rel_scale (
    .turns_i (turns_new),
    .pos_i   (upd.pos),
    .rel_o   (rel)
  );

  // Assemble the result
  always_comb begin
    res_d.temperature       = payload_q[15:8];
    res_d.torque            = payload_q[31:16];
    res_d.velocity          = payload_q[47:32];
    res_d.relative_position = rel;
    res_d.turn_count        = turns_new;
    res_d.raw_position      = upd.pos;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (upd.en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd.en) begin
      res_q       <= res_d;
      out_motor_q <= upd.motor;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {{(OUT_TDATA_W-$bits(res_t)){1'b0}}, res_q};
  assign m_axis_tuser_o[0] = out_motor_q;

  `MFU_ASSERT_NEXT(a_in_held, in_valid_q && !in_fire, in_valid_q, "stalled frame lost")
  `MFU_ASSERT_SAME(a_reject_drains, in_valid_q && !match, in_fire, "rejected frame stalled")
  `MFU_ASSERT_NEXT(a_match_shows, in_valid_q && match && in_fire, out_valid_q, "match gave no result")

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the motor feedback frame filter and turn unwrap.
module tb;
  import mfu_pkg::*;

  localparam int     COUNTS_PER_TURN = 8192;
  localparam int     DRAIN_CYCLES    = 8;
  localparam int     LIMIT_CYCLES    = 1000000;
  localparam longint REL_HI          = (longint'(1) << (REL_W - 1)) - 1;
  localparam longint REL_LO          = -(longint'(1) << (REL_W - 1));

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic                 ext;
    logic                 rem;
    logic [PAYLOAD_W-1:0] payload;
  } can_frame_t;

  typedef struct {
    logic motor;
    res_t fields;
  } feedback_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [IN_TUSER_W-1:0]  s_tuser   = '0;
  logic                   m_tready  = 1'b0;
  wire                    cfg_ready;
  wire                    s_tready;
  wire                    m_tvalid;
  wire [OUT_TDATA_W-1:0]  m_tdata;
  wire [OUT_TUSER_W-1:0]  m_tuser;

  // Register copies and per-motor tracking state of the predictor
  logic [ID_W-1:0]          first_id  = FIRST_ID_RST;
  logic [ID_W-1:0]          second_id = SECOND_ID_RST;
  logic [THR_W-1:0]         wrap_thr  = THR_RST;
  logic signed [POS_W-1:0]  last_pos [2] = '{default: '0};
  logic signed [POS_W-1:0]  turn_cnt [2] = '{default: '0};
  bit                       seen_motor [2] = '{default: 1'b0};

  feedback_t pending_feedback [$];
  int        mismatches     = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_request   = 0;

  motor_feedback_frame_unwrap #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Filter, decode and unwrap one accepted frame; queue the feedback it yields
  function automatic void predict_feedback(can_frame_t f);
    logic                    motor;
    logic signed [POS_W-1:0] pos;
    int                      diff;
    int                      thr;
    longint                  rel;
    feedback_t               want;
    if (f.ext || f.rem) return;
    if (f.id == first_id) motor = 1'b0;
    else if (f.id == second_id) motor = 1'b1;
    else return;
    pos = f.payload[63:48];
    if (seen_motor[motor]) begin
      diff = int'(pos) - int'(last_pos[motor]);
      thr  = int'(wrap_thr);
      if (diff > thr) begin
        if (turn_cnt[motor] != TURN_MIN) turn_cnt[motor] -= 16'sd1;
      end else if (diff < -thr) begin
        if (turn_cnt[motor] != TURN_MAX) turn_cnt[motor] += 16'sd1;
      end
    end
    seen_motor[motor] = 1'b1;
    last_pos[motor]   = pos;
    rel = longint'(turn_cnt[motor]) * COUNTS_PER_TURN + longint'(pos);
    if (rel > REL_HI) rel = REL_HI;
    if (rel < REL_LO) rel = REL_LO;
    want.motor                    = motor;
    want.fields.raw_position      = pos;
    want.fields.turn_count        = turn_cnt[motor];
    want.fields.relative_position = rel[REL_W-1:0];
    want.fields.velocity          = f.payload[47:32];
    want.fields.torque            = f.payload[31:16];
    want.fields.temperature       = f.payload[15:8];
    pending_feedback.push_back(want);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_feedback(logic motor, res_t got);
    feedback_t want;
    if (pending_feedback.size() == 0) begin
      $error("result transfer for motor %0d with no feedback pending", motor);
      mismatches++;
      return;
    end
    want = pending_feedback.pop_front();
    check_field("motor_index", want.motor, motor);
    check_field("raw_position", want.fields.raw_position, got.raw_position);
    check_field("turn_count", want.fields.turn_count, got.turn_count);
    check_field("relative_position", want.fields.relative_position,
                got.relative_position);
    check_field("velocity", want.fields.velocity, got.velocity);
    check_field("torque", want.fields.torque, got.torque);
    check_field("temperature", want.fields.temperature, got.temperature);
  endfunction

  // Check every result transfer against the oldest pending feedback
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      check_feedback(m_tuser[0], res_t'(m_tdata[$bits(res_t)-1:0]));
    end
  end

  // Drive the result ready: random stalls, or a long hold-off on request
  always begin : ready_driver
    int hold;
    @(posedge clk_i);
    if (hold_request > 0) begin
      hold         = hold_request;
      hold_request = 0;
      m_tready <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one frame after a random gap and hold it until the transfer
  task automatic send_frame(can_frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({f.payload, f.id});
    s_tuser  <= {f.rem, f.ext};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_feedback(f);
  endtask

  // Stop offering frames and wait until the block has gone quiet
  task automatic settle_pipeline();
    s_tvalid <= 1'b0;
    while (pending_feedback.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] value);
    settle_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_FIRST_ID:  first_id  = value[ID_W-1:0];
      CFG_SECOND_ID: second_id = value[ID_W-1:0];
      CFG_WRAP_THR:  wrap_thr  = value[THR_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic can_frame_t feedback_frame(logic [ID_W-1:0] id, logic [15:0] pos,
                                                logic [15:0] vel, logic [15:0] trq,
                                                logic [7:0] temp, logic [7:0] spare);
    can_frame_t f;
    f.id      = id;
    f.ext     = 1'b0;
    f.rem     = 1'b0;
    f.payload = {pos, vel, trq, temp, spare};
    return f;
  endfunction

  // Mostly frames for the tracked motors, with positions near the wrap threshold
  function automatic can_frame_t random_frame();
    can_frame_t              f;
    logic                    motor;
    int                      sel;
    int                      span;
    logic signed [POS_W-1:0] last;
    logic [POS_W-1:0]        pos;
    sel   = $urandom_range(99);
    motor = $urandom_range(1);
    if (sel < 78) f.id = motor ? second_id : first_id;
    else if (sel < 88) f.id = (motor ? second_id : first_id) ^ (11'd1 << $urandom_range(10));
    else f.id = 11'($urandom);
    f.ext     = ($urandom_range(99) < 6);
    f.rem     = ($urandom_range(99) < 6);
    f.payload = {$urandom, $urandom};
    last      = last_pos[motor];
    span      = int'(wrap_thr) + 256;
    case ($urandom_range(3))
      0, 1: pos = 16'(int'(last) + int'($urandom_range(2 * span)) - span);
      2: pos = 16'(int'(last) + ($urandom_range(1) ? span - 256 : 256 - span)
                   + int'($urandom_range(2)) - 1);
      default: pos = 16'($urandom);
    endcase
    f.payload[63:48] = pos;
    return f;
  endfunction

  task automatic program_random_setup();
    logic [ID_W-1:0] id;
    id = 11'($urandom);
    write_reg(CFG_FIRST_ID, 15'(id));
    write_reg(CFG_SECOND_ID, ($urandom_range(3) == 0) ? 15'(id) : 15'($urandom_range(2047)));
    case ($urandom_range(3))
      0: write_reg(CFG_WRAP_THR, 15'd0);
      1: write_reg(CFG_WRAP_THR, 15'h7FFF);
      default: write_reg(CFG_WRAP_THR, 15'($urandom_range(32767)));
    endcase
  endtask

  task automatic test_reset_defaults();
    // First frame of each motor: position stored, no turn step
    send_frame(feedback_frame(first_id, 16'sd1000, 16'sd12, -16'sd40, 8'd35, 8'h00));
    send_frame(feedback_frame(second_id, -16'sd1000, -16'sd7, 16'sd300, 8'd41, 8'h00));
  endtask

  task automatic test_rejected_frames();
    can_frame_t f;
    f = feedback_frame(first_id, 16'sd20000, 16'sd1, 16'sd2, 8'd3, 8'h00);
    f.ext = 1'b1;
    send_frame(f);
    f = feedback_frame(second_id, -16'sd20000, 16'sd1, 16'sd2, 8'd3, 8'h00);
    f.rem = 1'b1;
    send_frame(f);
    f.ext = 1'b1;
    send_frame(f);
    send_frame(feedback_frame(11'h207, 16'sd20000, 16'sd0, 16'sd0, 8'd0, 8'h00));
    send_frame(feedback_frame(11'h204, 16'sd20000, 16'sd0, 16'sd0, 8'd0, 8'h00));
    // State must be untouched: no turn step from the last stored position
    send_frame(feedback_frame(first_id, 16'sd1000, 16'sd5, 16'sd6, 8'd7, 8'h00));
  endtask

  task automatic test_wrap_detection();
    // Jumps of exactly the threshold, one past it, and full-range swings
    logic signed [POS_W-1:0] steps [7] = '{16'sd6000, 16'sd11001, 16'sd6001, 16'sd1000,
                                           16'sh7FFF, -16'sh8000, 16'sh7FFF};
    foreach (steps[i]) begin
      send_frame(feedback_frame(first_id, steps[i], 16'($urandom), 16'($urandom),
                                8'($urandom), 8'h00));
    end
  endtask

  task automatic test_payload_extremes();
    can_frame_t f;
    f = feedback_frame(second_id, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_frame(f);
    f.payload = '0;
    send_frame(f);
    // Spare byte set to make sure it is ignored
    f.payload = 64'h8000_7FFF_8000_7F5A;
    send_frame(f);
  endtask

  task automatic test_register_extremes();
    // Equal IDs: the first motor wins
    write_reg(CFG_FIRST_ID, 15'h123);
    write_reg(CFG_SECOND_ID, 15'h123);
    send_frame(feedback_frame(11'h123, 16'sd500, 16'sd1, 16'sd1, 8'd1, 8'h00));
    // Extreme IDs
    write_reg(CFG_FIRST_ID, 15'd0);
    write_reg(CFG_SECOND_ID, 15'd2047);
    send_frame(feedback_frame(11'd0, 16'sd400, 16'sd2, 16'sd2, 8'd2, 8'h00));
    send_frame(feedback_frame(11'd2047, 16'sd300, 16'sd3, 16'sd3, 8'd3, 8'h00));
    // Largest threshold: only swings beyond half the range count
    write_reg(CFG_WRAP_THR, 15'h7FFF);
    send_frame(feedback_frame(11'd0, 16'sh7FFF, 16'sd4, 16'sd4, 8'd4, 8'h00));
    send_frame(feedback_frame(11'd0, -16'sh8000, 16'sd5, 16'sd5, 8'd5, 8'h00));
    send_frame(feedback_frame(11'd0, 16'sd0, 16'sd6, 16'sd6, 8'd6, 8'h00));
    // Zero threshold: any movement counts, standing still does not
    write_reg(CFG_WRAP_THR, 15'd0);
    send_frame(feedback_frame(11'd0, 16'sd0, 16'sd7, 16'sd7, 8'd7, 8'h00));
    send_frame(feedback_frame(11'd0, 16'sd1, 16'sd8, 16'sd8, 8'd8, 8'h00));
  endtask

  // Random frames in chunks, with an idle-free chunk now and then
  task automatic test_random_traffic(int items, int send_pct, int stall_pct);
    for (int chunk = 0; chunk * 50 < items; chunk++) begin
      send_idle_pct  = (chunk % 4 == 3) ? 0 : send_pct;
      recv_stall_pct = (chunk % 4 == 3) ? 0 : stall_pct;
      repeat (50) send_frame(random_frame());
    end
    settle_pipeline();
  endtask

  task automatic test_backpressure();
    settle_pipeline();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Hold the result side off so the block fills and stalls its input
    hold_request   = 300;
    repeat (30) send_frame(random_frame());
    settle_pipeline();
    repeat (30) send_frame(random_frame());
    settle_pipeline();
  endtask

  // Step one motor a count at a time so that every frame moves its turn count
  task automatic drive_turn_steps(logic motor, logic up, int steps);
    logic [POS_W-1:0] pos;
    pos = last_pos[motor];
    repeat (steps) begin
      pos = up ? pos - 16'd1 : pos + 16'd1;
      send_frame(feedback_frame(motor ? second_id : first_id, pos, 16'($urandom),
                                16'($urandom), 8'($urandom), 8'($urandom)));
    end
  endtask

  task automatic test_turn_stepping();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_FIRST_ID, 15'h205);
    write_reg(CFG_SECOND_ID, 15'h206);
    write_reg(CFG_WRAP_THR, 15'd0);
    drive_turn_steps(1'b0, 1'b1, 60);
    drive_turn_steps(1'b1, 1'b0, 60);
    settle_pipeline();
    // Random traffic with both motors carrying a turn offset
    write_reg(CFG_WRAP_THR, 15'd5000);
    test_random_traffic(200, 28, 28);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_rejected_frames();
    test_wrap_detection();
    test_payload_extremes();
    test_register_extremes();
    program_random_setup();
    test_random_traffic(450, 0, 0);
    program_random_setup();
    test_random_traffic(450, 80, 0);
    program_random_setup();
    test_random_traffic(450, 0, 80);
    program_random_setup();
    test_random_traffic(450, 28, 28);
    test_backpressure();
    test_turn_stepping();
    settle_pipeline();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("tb: failure");
    $finish;
  end

endmodule
